@@ rtl/thermistor_code_to_celsius_macros.svh @@
// ----------------------------------------------------------------------------
// Thermistor code to Celsius: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_CODE_TO_CELSIUS_MACROS_SVH
`define THERMISTOR_CODE_TO_CELSIUS_MACROS_SVH

// assertion that is switched off while reset is held
`define TCC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that is checked on every edge, reset included
`define TCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tcc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths, constants and register codes of the thermistor converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    // field and register widths
    localparam int CODE_BITS_DEF = 15;
    localparam int ADC_W         = 15;
    localparam int TEMP_W        = 24;
    localparam int COEF_W        = 48;
    localparam int OHMS_W        = 16;
    localparam int CFG_W         = 48;
    localparam int CFG_IDX_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_OHMS = 2'd3;

    localparam logic [OHMS_W-1:0] REF_OHMS_RST = 16'd18000;

    // datapath widths
    localparam int R16_W  = 32;   // resistance, Q16 ohms
    localparam int LOG_N  = 32;   // fraction bits of the log2
    localparam int MUL_W  = 48;   // signed operand width of the Q32 multiplier
    localparam int MULO_W = 64;   // signed result width of the Q32 multiplier
    localparam int D_W    = 60;   // Steinhart-Hart denominator, Q52
    localparam int XQ_W   = 26;   // kelvin quotient bits, units of 1/1280

    // ln(2) in Q32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    // 5 * 2^60, numerator of the reciprocal
    localparam logic [63:0] RECIP_NUM = 64'h5000_0000_0000_0000;
    // 273.15 K in units of 1/1280
    localparam logic [26:0] KELVIN_OFS = 27'd349632;
    // ceil(2^30 / 5), exact divide by five for values below 2^30
    localparam logic [27:0] RECIP5       = 28'd214748365;
    localparam int          RECIP5_SHIFT = 30;

    localparam logic [TEMP_W-1:0] TEMP_MAX = 24'h7F_FFFF;

endpackage

`default_nettype wire

@@ rtl/tcc_div_cell.sv @@
// ----------------------------------------------------------------------------
// tcc_div_cell
// One restoring long-division step: brings down one dividend bit, makes one
// quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_div_cell #(
    parameter int RW  = 16,
    parameter int LW  = 32,
    parameter int QW  = 32,
    parameter int SBW = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire logic [RW-1:0]  i_rem,
    input  wire logic [LW-1:0]  i_low,
    input  wire logic [RW-1:0]  i_div,
    input  wire logic [QW-1:0]  i_q,
    input  wire logic [SBW-1:0] i_sb,
    output logic                o_vld,
    output logic [RW-1:0]       o_rem,
    output logic [LW-1:0]       o_low,
    output logic [RW-1:0]       o_div,
    output logic [QW-1:0]       o_q,
    output logic [SBW-1:0]      o_sb
);

    logic [RW:0]    sh;
    logic [RW:0]    diff;
    logic           ge;
    logic [RW-1:0]  n_rem;

    // shift in the next dividend bit and try the subtract
    assign sh    = {i_rem, i_low[LW-1]};
    assign diff  = sh - {1'b0, i_div};
    assign ge    = (sh >= {1'b0, i_div});
    assign n_rem = ge ? diff[RW-1:0] : sh[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_low <= {i_low[LW-2:0], 1'b0};
            o_div <= i_div;
            o_q   <= {i_q[QW-2:0], ge};
            o_sb  <= i_sb;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcc_log_cell.sv @@
// ----------------------------------------------------------------------------
// tcc_log_cell
// One log2 fraction step: squares the normalized mantissa, renormalizes it
// and shifts the new fraction bit into the accumulated fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_log_cell #(
    parameter int SBW = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire logic [31:0]    i_m,
    input  wire logic [31:0]    i_frac,
    input  wire logic [SBW-1:0] i_sb,
    output logic                o_vld,
    output logic [31:0]         o_m,
    output logic [31:0]         o_frac,
    output logic [SBW-1:0]      o_sb
);

    logic [63:0] sq;
    logic [32:0] s;

    // mantissa in [2^31, 2^32); square in Q31 lands in [2^31, 2^33)
    assign sq = 64'(i_m) * 64'(i_m);
    assign s  = sq[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_m    <= s[32] ? s[32:1] : s[31:0];
            o_frac <= {i_frac[30:0], s[32]};
            o_sb   <= i_sb;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcc_mul.sv @@
// ----------------------------------------------------------------------------
// tcc_mul
// Signed Q32 multiply, round(x*y / 2^32) with halves away from zero.
// Three stages: magnitudes, 32-bit partial products, sum and round.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_mul #(
    parameter int SBW = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic signed [tcc_pkg::MUL_W-1:0] i_x,
    input  wire logic signed [tcc_pkg::MUL_W-1:0] i_y,
    input  wire logic [SBW-1:0]                i_sb,
    output logic                               o_vld,
    output logic signed [tcc_pkg::MULO_W-1:0]  o_p,
    output logic [SBW-1:0]                     o_sb
);

    localparam int W = tcc_pkg::MUL_W;

    logic           r1_vld, r2_vld;
    logic           r1_neg, r2_neg;
    logic [W-1:0]   r1_ax, r1_ay;
    logic [SBW-1:0] r1_sb, r2_sb;
    logic [63:0]    r2_p00;
    logic [47:0]    r2_p01, r2_p10;
    logic [31:0]    r2_p11;
    logic [95:0]    full;
    logic [61:0]    mag;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            o_vld  <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            o_vld  <= r2_vld;
        end
    end

    // sum of partial products plus the rounding half
    assign full = 96'(r2_p00) + (96'(r2_p01) << 32) + (96'(r2_p10) << 32)
                + (96'(r2_p11) << 64) + 96'h8000_0000;
    assign mag  = full[93:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: sign and magnitudes
            r1_neg <= i_x[W-1] ^ i_y[W-1];
            r1_ax  <= i_x[W-1] ? W'(-i_x) : W'(i_x);
            r1_ay  <= i_y[W-1] ? W'(-i_y) : W'(i_y);
            r1_sb  <= i_sb;
            // stage 2: partial products
            r2_p00 <= 64'(r1_ax[31:0]) * 64'(r1_ay[31:0]);
            r2_p01 <= 48'(r1_ax[31:0]) * 48'(r1_ay[W-1:32]);
            r2_p10 <= 48'(r1_ax[W-1:32]) * 48'(r1_ay[31:0]);
            r2_p11 <= 32'(r1_ax[W-1:32]) * 32'(r1_ay[W-1:32]);
            r2_neg <= r1_neg;
            r2_sb  <= r1_sb;
            // stage 3: round and apply sign
            o_p    <= r2_neg ? -$signed(64'(mag)) : $signed(64'(mag));
            o_sb   <= r2_sb;
        end
    end

endmodule

`default_nettype wire

@@ rtl/thermistor_code_to_celsius.sv @@
// Throughput: one transaction per cycle; every stage is a pipeline register
// and the reciprocal division and log2 chains hold one item per cell.
// A stalled output freezes the whole pipeline; o_stall follows it directly.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the register
// defaults: coefficients zero, reference 18000 ohms.
// ----------------------------------------------------------------------------
// thermistor_code_to_celsius
// Converter code to resistance, natural log, Steinhart-Hart polynomial,
// reciprocal and Celsius conversion in 1/256 degree, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_code_to_celsius #(
    parameter int CODE_BITS = tcc_pkg::CODE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [tcc_pkg::ADC_W-1:0]          i_adc_code,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [tcc_pkg::TEMP_W-1:0]       o_temperature,
    output logic                                    o_invalid,
    output logic                                    o_saturated,
    input  wire logic                               i_cfg_we,
    input  wire logic [tcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tcc_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int PROD_W = CODE_BITS + 16;
    localparam int N_W    = PROD_W + 16;
    localparam int RR_W   = CODE_BITS + 3;
    localparam int NT     = (CODE_BITS + 32 + CODE_BITS - 1) / CODE_BITS;
    localparam int R16_W  = tcc_pkg::R16_W;
    localparam int LOG_N  = tcc_pkg::LOG_N;
    localparam int MUL_W  = tcc_pkg::MUL_W;
    localparam int MULO_W = tcc_pkg::MULO_W;
    localparam int D_W    = tcc_pkg::D_W;
    localparam int XQ_W   = tcc_pkg::XQ_W;
    localparam logic [CODE_BITS-1:0] FS_V    = CODE_BITS'((2**CODE_BITS) - 1);
    localparam logic [15:0]          HALF_FS = 16'((2**(CODE_BITS-1)) - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [tcc_pkg::COEF_W-1:0] r_coef_a, r_coef_b, r_coef_c;
    logic [tcc_pkg::OHMS_W-1:0]        r_ref_ohms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a   <= '0;
            r_coef_b   <= '0;
            r_coef_c   <= '0;
            r_ref_ohms <= tcc_pkg::REF_OHMS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcc_pkg::REG_COEF_A:   r_coef_a   <= $signed(i_cfg_data);
                tcc_pkg::REG_COEF_B:   r_coef_b   <= $signed(i_cfg_data);
                tcc_pkg::REG_COEF_C:   r_coef_c   <= $signed(i_cfg_data);
                tcc_pkg::REG_REF_OHMS: r_ref_ohms <= i_cfg_data[tcc_pkg::OHMS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: everything moves unless a result is held
    // ------------------------------------------------------------------
    logic en;
    logic r_out_vld;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // ------------------------------------------------------------------
    // stage 0: code times reference ohms
    // ------------------------------------------------------------------
    logic [31:0]          code_ext;
    logic [CODE_BITS-1:0] code;
    logic                 r_s0_vld, r_s0_zero;
    logic [PROD_W-1:0]    r_s0_prod;

    assign code_ext = 32'(i_adc_code);
    assign code     = code_ext[CODE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_prod <= PROD_W'(code) * PROD_W'(r_ref_ohms);
            r_s0_zero <= (code == '0);
        end
    end

    // ------------------------------------------------------------------
    // stage R1: (prod*2^16 + FS/2) / FS with FS = 2^n - 1, first estimate
    // from the truncated series N/2^n + N/2^2n + ..., never above the quotient
    // ------------------------------------------------------------------
    logic [N_W-1:0]   nval;
    logic [N_W-1:0]   qsum;
    logic             r_r1_vld, r_r1_zero;
    logic [N_W-1:0]   r_r1_n;
    logic [R16_W-1:0] r_r1_qe;

    assign nval = {r_s0_prod, HALF_FS};

    always_comb begin
        qsum = '0;
        for (int k = 1; k <= NT; k++) begin
            qsum = qsum + (nval >> (k * CODE_BITS));
        end
    end

    // ------------------------------------------------------------------
    // stage R2: remainder N - qe*FS, a few divisors at most
    // ------------------------------------------------------------------
    logic [N_W-1:0]   rfull;
    logic             r_r2_vld, r_r2_zero;
    logic [RR_W-1:0]  r_r2_r;
    logic [R16_W-1:0] r_r2_qe;

    assign rfull = r_r1_n - (N_W'(r_r1_qe) << CODE_BITS) + N_W'(r_r1_qe);

    // ------------------------------------------------------------------
    // stage R3: fold the remainder, r = a*FS + (a + b)
    // ------------------------------------------------------------------
    logic [2:0]           ra;
    logic [CODE_BITS-1:0] rb;
    logic                 rc;
    logic                 r_r3_vld, r_r3_zero;
    logic [R16_W-1:0]     r_r3_q;

    assign ra = r_r2_r[RR_W-1:CODE_BITS];
    assign rb = r_r2_r[CODE_BITS-1:0];
    assign rc = (({1'b0, rb} + (CODE_BITS+1)'(ra)) >= {1'b0, FS_V});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_vld <= 1'b0;
            r_r2_vld <= 1'b0;
            r_r3_vld <= 1'b0;
        end else if (en) begin
            r_r1_vld <= r_s0_vld;
            r_r2_vld <= r_r1_vld;
            r_r3_vld <= r_r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1_n    <= nval;
            r_r1_qe   <= qsum[R16_W-1:0];
            r_r1_zero <= r_s0_zero;
            r_r2_r    <= rfull[RR_W-1:0];
            r_r2_qe   <= r_r1_qe;
            r_r2_zero <= r_r1_zero;
            r_r3_q    <= r_r2_qe + R16_W'(ra) + R16_W'(rc);
            r_r3_zero <= r_r2_zero;
        end
    end

    // ------------------------------------------------------------------
    // stage L0: leading one of the resistance
    // ------------------------------------------------------------------
    logic [R16_W-1:0] r16;
    logic [4:0]       lead;
    logic             r_l0_vld, r_l0_inv;
    logic [R16_W-1:0] r_l0_r16;
    logic [4:0]       r_l0_p;

    assign r16 = r_r3_q;

    always_comb begin
        lead = '0;
        for (int i = 0; i < R16_W; i++) begin
            if (r16[i]) begin
                lead = 5'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage L1: normalize mantissa to Q31
    // ------------------------------------------------------------------
    logic        r_l1_vld, r_l1_inv;
    logic [31:0] r_l1_m;
    logic [4:0]  r_l1_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l0_vld <= 1'b0;
            r_l1_vld <= 1'b0;
        end else if (en) begin
            r_l0_vld <= r_r3_vld;
            r_l1_vld <= r_l0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l0_r16 <= r16;
            r_l0_p   <= lead;
            r_l0_inv <= r_r3_zero || (r16 == '0);
            r_l1_m   <= r_l0_r16 << (5'd31 - r_l0_p);
            r_l1_p   <= r_l0_p;
            r_l1_inv <= r_l0_inv;
        end
    end

    // ------------------------------------------------------------------
    // log2 fraction chain, one bit per cell; sideband {p, invalid}
    // ------------------------------------------------------------------
    logic        lg_vld  [0:LOG_N];
    logic [31:0] lg_m    [0:LOG_N];
    logic [31:0] lg_frac [0:LOG_N];
    logic [5:0]  lg_sb   [0:LOG_N];

    assign lg_vld[0]  = r_l1_vld;
    assign lg_m[0]    = r_l1_m;
    assign lg_frac[0] = '0;
    assign lg_sb[0]   = {r_l1_p, r_l1_inv};

    for (genvar g = 0; g < LOG_N; g++) begin : g_log
        tcc_log_cell #(.SBW(6)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (lg_vld[g]),
            .i_m    (lg_m[g]),
            .i_frac (lg_frac[g]),
            .i_sb   (lg_sb[g]),
            .o_vld  (lg_vld[g+1]),
            .o_m    (lg_m[g+1]),
            .o_frac (lg_frac[g+1]),
            .o_sb   (lg_sb[g+1])
        );
    end

    // ------------------------------------------------------------------
    // stages L2, L3: ln(R) = (p-16)*ln2 + round(frac*ln2) in Q32
    // ------------------------------------------------------------------
    logic [4:0]         lg_p;
    logic signed [5:0]  ip;
    logic               r_l2_vld, r_l2_inv;
    logic [63:0]        r_l2_fprod;
    logic signed [37:0] r_l2_ipl;
    logic [64:0]        frnd;
    logic signed [37:0] lsum;
    logic               r_l3_vld, r_l3_inv;
    logic signed [MUL_W-1:0] r_l3_l;

    assign lg_p = lg_sb[LOG_N][5:1];
    assign ip   = $signed({1'b0, lg_p}) - 6'sd16;
    assign frnd = 65'(r_l2_fprod) + 65'h8000_0000;
    assign lsum = r_l2_ipl + $signed({6'b0, frnd[63:32]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_vld <= 1'b0;
            r_l3_vld <= 1'b0;
        end else if (en) begin
            r_l2_vld <= lg_vld[LOG_N];
            r_l3_vld <= r_l2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l2_fprod <= 64'(lg_frac[LOG_N]) * 64'(tcc_pkg::LN2_Q32);
            r_l2_ipl   <= 38'(ip) * $signed({6'b0, tcc_pkg::LN2_Q32});
            r_l2_inv   <= lg_sb[LOG_N][0];
            r_l3_l     <= MUL_W'(lsum);
            r_l3_inv   <= r_l2_inv;
        end
    end

    // ------------------------------------------------------------------
    // polynomial: L2 = L*L, L3 = L2*L, then B*L and C*L3 side by side
    // ------------------------------------------------------------------
    logic                     m1_vld, m2_vld, m3_vld, m4_vld;
    logic signed [MULO_W-1:0] m1_p, m2_p, m3_p, m4_p;
    logic [MUL_W:0]           m1_sb, m2_sb;
    logic [0:0]               m3_sb, m4_sb;
    logic signed [MUL_W-1:0]  m1_l, m2_l;

    tcc_mul #(.SBW(MUL_W+1)) u_mul_l2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_l3_vld),
        .i_x    (r_l3_l),
        .i_y    (r_l3_l),
        .i_sb   ({r_l3_l, r_l3_inv}),
        .o_vld  (m1_vld),
        .o_p    (m1_p),
        .o_sb   (m1_sb)
    );

    assign m1_l = $signed(m1_sb[MUL_W:1]);

    tcc_mul #(.SBW(MUL_W+1)) u_mul_l3 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (m1_vld),
        .i_x    ($signed(m1_p[MUL_W-1:0])),
        .i_y    (m1_l),
        .i_sb   (m1_sb),
        .o_vld  (m2_vld),
        .o_p    (m2_p),
        .o_sb   (m2_sb)
    );

    assign m2_l = $signed(m2_sb[MUL_W:1]);

    tcc_mul #(.SBW(1)) u_mul_b (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (m2_vld),
        .i_x    (r_coef_b),
        .i_y    (m2_l),
        .i_sb   (m2_sb[0]),
        .o_vld  (m3_vld),
        .o_p    (m3_p),
        .o_sb   (m3_sb)
    );

    tcc_mul #(.SBW(1)) u_mul_c (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (m2_vld),
        .i_x    (r_coef_c),
        .i_y    ($signed(m2_p[MUL_W-1:0])),
        .i_sb   (m2_sb[0]),
        .o_vld  (m4_vld),
        .o_p    (m4_p),
        .o_sb   (m4_sb)
    );

    // ------------------------------------------------------------------
    // stage D: denominator A + B*L + C*L3
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] dsum;
    logic                  r_d_vld, r_d_inv;
    logic [D_W-1:0]        r_d;

    assign dsum = D_W'(r_coef_a) + $signed(m3_p[D_W-1:0]) + $signed(m4_p[D_W-1:0]);

    // ------------------------------------------------------------------
    // stage N: numerator 5*2^60 + D/2, overflow check on the top bits
    // ------------------------------------------------------------------
    logic [63:0]     num;
    logic            r_n_vld, r_n_inv, r_n_sat;
    logic [D_W-1:0]  r_n_rem;
    logic [XQ_W-1:0] r_n_low;
    logic [D_W-1:0]  r_n_div;

    assign num = tcc_pkg::RECIP_NUM + 64'(r_d[D_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_n_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= m3_vld && m4_vld;
            r_n_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d     <= dsum;
            r_d_inv <= m3_sb[0] || m4_sb[0] || (dsum <= 0);
            r_n_rem <= D_W'(num[63:XQ_W]);
            r_n_low <= num[XQ_W-1:0];
            r_n_div <= r_d;
            r_n_inv <= r_d_inv;
            r_n_sat <= ({(D_W+XQ_W-64)'(0), num[63:XQ_W]} >= r_d);
        end
    end

    // ------------------------------------------------------------------
    // reciprocal division chain; sideband {invalid, saturated}
    // ------------------------------------------------------------------
    logic             rc_vld [0:XQ_W];
    logic [D_W-1:0]   rc_rem [0:XQ_W];
    logic [XQ_W-1:0]  rc_low [0:XQ_W];
    logic [D_W-1:0]   rc_div [0:XQ_W];
    logic [XQ_W-1:0]  rc_q   [0:XQ_W];
    logic [1:0]       rc_sb  [0:XQ_W];

    assign rc_vld[0] = r_n_vld;
    assign rc_rem[0] = r_n_rem;
    assign rc_low[0] = r_n_low;
    assign rc_div[0] = r_n_div;
    assign rc_q[0]   = '0;
    assign rc_sb[0]  = {r_n_inv, r_n_sat};

    for (genvar g = 0; g < XQ_W; g++) begin : g_recip
        tcc_div_cell #(.RW(D_W), .LW(XQ_W), .QW(XQ_W), .SBW(2)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (rc_vld[g]),
            .i_rem  (rc_rem[g]),
            .i_low  (rc_low[g]),
            .i_div  (rc_div[g]),
            .i_q    (rc_q[g]),
            .i_sb   (rc_sb[g]),
            .o_vld  (rc_vld[g+1]),
            .o_rem  (rc_rem[g+1]),
            .o_low  (rc_low[g+1]),
            .o_div  (rc_div[g+1]),
            .o_q    (rc_q[g+1]),
            .o_sb   (rc_sb[g+1])
        );
    end

    // ------------------------------------------------------------------
    // stages Q1, Q2: subtract 273.15 K, divide magnitude by five
    // ------------------------------------------------------------------
    logic signed [26:0] ysub;
    logic [26:0]        ymag;
    logic               r_q1_vld, r_q1_neg, r_q1_inv, r_q1_sat;
    logic [26:0]        r_q1_v;
    logic [54:0]        q5_prod;
    logic               r_q2_vld, r_q2_neg, r_q2_inv, r_q2_sat;
    logic [23:0]        r_q2_q;

    assign ysub    = $signed({1'b0, rc_q[XQ_W]}) - $signed(tcc_pkg::KELVIN_OFS);
    assign ymag    = ysub[26] ? 27'(-ysub) : 27'(ysub);
    assign q5_prod = 55'(r_q1_v) * 55'(tcc_pkg::RECIP5);

    // ------------------------------------------------------------------
    // output stage: sign, clamp, flags
    // ------------------------------------------------------------------
    logic signed [24:0] tval;

    assign tval = r_q2_neg ? -$signed({1'b0, r_q2_q}) : $signed({1'b0, r_q2_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_vld  <= 1'b0;
            r_q2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_q1_vld  <= rc_vld[XQ_W];
            r_q2_vld  <= r_q1_vld;
            r_out_vld <= r_q2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_v   <= ymag + 27'd2;
            r_q1_neg <= ysub[26];
            r_q1_inv <= rc_sb[XQ_W][1];
            r_q1_sat <= rc_sb[XQ_W][0];
            r_q2_q   <= q5_prod[tcc_pkg::RECIP5_SHIFT +: 24];
            r_q2_neg <= r_q1_neg;
            r_q2_inv <= r_q1_inv;
            r_q2_sat <= r_q1_sat;
            if (r_q2_inv) begin
                o_temperature <= '0;
                o_invalid     <= 1'b1;
                o_saturated   <= 1'b0;
            end else if (r_q2_sat || (!r_q2_neg && r_q2_q[23])) begin
                o_temperature <= $signed(tcc_pkg::TEMP_MAX);
                o_invalid     <= 1'b0;
                o_saturated   <= 1'b1;
            end else begin
                o_temperature <= tval[23:0];
                o_invalid     <= 1'b0;
                o_saturated   <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;

endmodule

`default_nettype wire

@@ rtl/tcc_checker.sv @@
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the thermistor converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermistor_code_to_celsius_macros.svh"

module tcc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [23:0] o_temperature,
    input wire logic        o_invalid,
    input wire logic        o_saturated
);

    // an invalid result carries a zero temperature and no clamp
    `TCC_ASSERT_RST(a_invalid_zero, i_clk, i_rst_n, (o_valid && o_invalid) |-> (o_temperature == 24'd0 && !o_saturated), "invalid result not zeroed")

    // only the upper bound can be reached: kelvin is never negative
    `TCC_ASSERT_RST(a_sat_high, i_clk, i_rst_n, (o_valid && o_saturated) |-> (o_temperature == 24'h7F_FFFF), "clamp not at upper bound")

    // the input side is held back only by a waiting output transaction
    `TCC_ASSERT_RST(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "input stalled without cause")

    // a stalled result stays put
    `TCC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_temperature)), "stalled result changed")

    // reset empties the pipeline
    `TCC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

endmodule

bind thermistor_code_to_celsius tcc_checker u_tcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_temperature(o_temperature),
    .o_invalid    (o_invalid),
    .o_saturated  (o_saturated)
);

`default_nettype wire

@@ dv/tb_thermistor_code_to_celsius.sv @@
// ----------------------------------------------------------------------------
// tb_thermistor_code_to_celsius
// Self-checking bench for the thermistor converter. An integer Steinhart-Hart
// predictor computes each temperature at input acceptance. A monitor then
// compares every output transaction in order. The bench runs several
// coefficient and reference settings with random sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_thermistor_code_to_celsius;

    localparam int CODE_BITS = tcc_pkg::CODE_BITS_DEF;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic signed [tcc_pkg::TEMP_W-1:0] temp;
        logic                              inv;
        logic                              sat;
    } t_celsius;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    logic [tcc_pkg::ADC_W-1:0]            i_adc_code = '0;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic signed [tcc_pkg::TEMP_W-1:0]    o_temperature;
    logic                                 o_invalid;
    logic                                 o_saturated;
    logic                                 i_cfg_we = 1'b0;
    logic [tcc_pkg::CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [tcc_pkg::CFG_W-1:0]            i_cfg_data = '0;

    thermistor_code_to_celsius #(.CODE_BITS(CODE_BITS)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the registers
    longint  sh_a, sh_b, sh_c;
    longint unsigned ref_ohms;

    logic [tcc_pkg::ADC_W-1:0] code_queue[$];
    t_celsius                  temp_queue[$];
    int                        idle_mode = 0;
    int                        err_count = 0;
    int                        wdog = 0;

    // round(x*y / 2^32), halves away from zero, magnitude kept to 62 bits
    function automatic longint q32_mul(longint x, longint y);
        logic [127:0] ux, uy, pr;
        logic [63:0]  r;
        logic         neg;
        neg = (x < 0) != (y < 0);
        ux  = (x < 0) ? 128'(-x) : 128'(x);
        uy  = (y < 0) ? 128'(-y) : 128'(y);
        pr  = ux * uy + 128'h8000_0000;
        r   = pr[95:32];
        r[63:62] = 2'b00;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_celsius code_to_celsius(logic [tcc_pkg::ADC_W-1:0] code_in);
        logic [63:0]  fs, code, r16, m, frac, x;
        logic [127:0] fl;
        longint       lnr, l3, d, y, t;
        int           p;
        t_celsius     res;
        res  = '{temp: '0, inv: 1'b1, sat: 1'b0};
        fs   = (64'd1 << CODE_BITS) - 64'd1;
        code = 64'(code_in) & fs;
        r16  = (code * ref_ohms * 64'd65536 + fs / 2) / fs;
        if (code == 0 || r16 == 0) return res;
        // log2 by repeated squaring of the normalized mantissa
        p = 0;
        for (int i = 0; i < 64; i++) if (r16[i]) p = i;
        m = (p <= 31) ? (r16 << (31 - p)) : (r16 >> (p - 31));
        frac = '0;
        for (int i = 0; i < tcc_pkg::LOG_N; i++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        fl  = (128'(frac) * 128'(tcc_pkg::LN2_Q32) + 128'h8000_0000) >> 32;
        lnr = longint'(p - 16) * longint'(tcc_pkg::LN2_Q32) + longint'(fl[63:0]);
        l3  = q32_mul(q32_mul(lnr, lnr), lnr);
        d   = sh_a + q32_mul(sh_b, lnr) + q32_mul(sh_c, l3);
        if (d <= 0) return res;
        x = (tcc_pkg::RECIP_NUM + 64'(d) / 2) / 64'(d);
        y = longint'(x) - longint'(tcc_pkg::KELVIN_OFS);
        t = (y >= 0) ? (y + 2) / 5 : -((-y + 2) / 5);
        res.inv = 1'b0;
        if (t > 8388607) begin
            t = 8388607;
            res.sat = 1'b1;
        end else if (t < -8388608) begin
            t = -8388608;
            res.sat = 1'b1;
        end
        res.temp = t[tcc_pkg::TEMP_W-1:0];
        return res;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // input driver: predicts each transaction as it is accepted
    always @(posedge i_clk) begin
        logic                      nv;
        logic [tcc_pkg::ADC_W-1:0] nc;
        int                        gap;
        nv = i_valid;
        nc = i_adc_code;
        gap = (idle_mode == 0) ? 19 : (idle_mode == 1) ? 70 : 0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                temp_queue.push_back(code_to_celsius(i_adc_code));
                nv = 1'b0;
            end
            if (!nv && code_queue.size() > 0 && !roll(gap)) begin
                nv = 1'b1;
                nc = code_queue.pop_front();
            end
        end
        i_valid    <= nv;
        i_adc_code <= nc;
    end

    // output monitor and receiver stall
    always @(posedge i_clk) begin
        t_celsius want;
        int       hold;
        hold = (idle_mode == 0) ? 70 : (idle_mode == 1) ? 19 : 0;
        if (i_rst_n && o_valid && !i_stall) begin
            if (temp_queue.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected transaction: temp %0d inv %0b sat %0b",
                             o_temperature, o_invalid, o_saturated);
            end else begin
                want = temp_queue.pop_front();
                if (o_temperature !== want.temp || o_invalid !== want.inv ||
                    o_saturated !== want.sat) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 want.temp, want.inv, want.sat,
                                 o_temperature, o_invalid, o_saturated);
                end
            end
        end
        i_stall <= roll(hold);
    end

    // watchdog on idle cycles: no transaction on either side, no write, no reset
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [tcc_pkg::CFG_IDX_W-1:0] idx,
                             logic [tcc_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tcc_pkg::REG_COEF_A:
                sh_a = longint'(signed'(data[tcc_pkg::COEF_W-1:0]));
            tcc_pkg::REG_COEF_B:
                sh_b = longint'(signed'(data[tcc_pkg::COEF_W-1:0]));
            tcc_pkg::REG_COEF_C:
                sh_c = longint'(signed'(data[tcc_pkg::COEF_W-1:0]));
            tcc_pkg::REG_REF_OHMS:
                ref_ohms = 64'(data[tcc_pkg::OHMS_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_all(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                           logic [15:0] r);
        write_reg(tcc_pkg::REG_COEF_A, a);
        write_reg(tcc_pkg::REG_COEF_B, b);
        write_reg(tcc_pkg::REG_COEF_C, c);
        write_reg(tcc_pkg::REG_REF_OHMS, 48'(r));
    endtask

    task automatic drain();
        while (code_queue.size() > 0 || temp_queue.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (130) @(posedge i_clk);
    endtask

    function automatic logic [tcc_pkg::ADC_W-1:0] rand_code();
        case ($urandom_range(3, 0))
            0: return tcc_pkg::ADC_W'($urandom_range(64, 0));
            1: return tcc_pkg::ADC_W'(32767 - $urandom_range(64, 0));
            2: return tcc_pkg::ADC_W'($urandom) >> $urandom_range(14, 0);
            default: return tcc_pkg::ADC_W'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom} >> $urandom_range(40, 0));
    endfunction

    initial begin
        sh_a = 0;
        sh_b = 0;
        sh_c = 0;
        ref_ohms = 64'(tcc_pkg::REF_OHMS_RST);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: zero denominator, every result invalid
        for (int i = 0; i < 8; i++) code_queue.push_back(rand_code());
        code_queue.push_back('0);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            idle_mode = (ph < 3) ? 0 : (ph < 6) ? 1 : 2;
            case (ph)
                // typical 10k NTC coefficients
                0: set_all(48'd5066848262000, 48'd1057030000000, 48'd385780000,
                           16'd18000);
                1: set_all(48'd5066848262000, 48'd1057030000000, 48'd385780000,
                           16'd1);
                2: set_all(48'd5066848262000, 48'd1057030000000, 48'd385780000,
                           16'd65535);
                // largest positive denominator term, high reference
                3: set_all(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                           48'h7FFF_FFFF_FFFF, 16'd65535);
                // tiny positive A alone: saturates high
                4: set_all(48'd1, 48'd0, 48'd0, 16'd1);
                // most negative coefficients: non-positive denominator
                5: set_all(48'h8000_0000_0000, 48'h8000_0000_0000,
                           48'h8000_0000_0000, 16'd18000);
                default: set_all(rand48(),
                                 rand48() ^ {1'($urandom_range(1, 0)), 47'd0},
                                 rand48(), 16'($urandom_range(65535, 1)));
            endcase
            if (ph == 0) begin
                code_queue.push_back('0);
                code_queue.push_back(15'd1);
                code_queue.push_back(15'd2);
                code_queue.push_back(15'd32767);
                code_queue.push_back(15'd32766);
                code_queue.push_back(15'd16383);
                code_queue.push_back(15'd16384);
                for (int b = 0; b < tcc_pkg::ADC_W; b++)
                    code_queue.push_back(tcc_pkg::ADC_W'(1) << b);
            end
            for (int i = 0; i < 125; i++) code_queue.push_back(rand_code());
            drain();
        end

        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
